// ===== rtl/uvsg_pkg.sv =====
`default_nettype none
package uvsg_pkg;

    localparam int MAX_SLICES   = 256;
    localparam int MAX_STACKS   = 256;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_BITS     = 16;
    localparam int FIFO_DEPTH   = 4;
    localparam int PTR_W        = $clog2(FIFO_DEPTH);

    localparam logic [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SLICES = 2'd1;
    localparam logic [1:0] REG_STACKS = 2'd2;

    localparam logic [15:0] RADIUS_RST = 16'd256;
    localparam logic [8:0]  SLICES_RST = 9'd16;
    localparam logic [8:0]  STACKS_RST = 9'd8;

    typedef struct packed {
        logic [16:0] k1;
        logic [16:0] k2;
        logic        up;
        logic        lo;
    } side_t;

    typedef struct packed {
        logic [8:0] row;
        logic [8:0] col;
        logic [8:0] slices;
        logic [8:0] stacks;
        side_t      side;
    } item_t;

    typedef struct packed {
        logic [8:0]  slices;
        logic [8:0]  stacks;
        logic [8:0]  rem_u;
        logic [8:0]  rem_v;
        logic [16:0] q_u;
        logic [16:0] q_v;
        side_t       side;
    } div_t;

    typedef struct packed {
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        side_t       side;
    } post_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        begin
            unique case (i)
                0:  r = 32'd536870912;
                1:  r = 32'd316933406;
                2:  r = 32'd167458907;
                3:  r = 32'd85004756;
                4:  r = 32'd42667331;
                5:  r = 32'd21354465;
                6:  r = 32'd10679838;
                7:  r = 32'd5340245;
                8:  r = 32'd2670163;
                9:  r = 32'd1335087;
                10: r = 32'd667544;
                11: r = 32'd333772;
                12: r = 32'd166886;
                13: r = 32'd83443;
                14: r = 32'd41722;
                15: r = 32'd20861;
                16: r = 32'd10430;
                17: r = 32'd5215;
                18: r = 32'd2608;
                19: r = 32'd1304;
                20: r = 32'd652;
                21: r = 32'd326;
                22: r = 32'd163;
                23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    // round-shifted position, saturated to +-65535
    function automatic logic [16:0] sat_pos(input logic signed [63:0] v);
        logic [16:0] r;
        begin
            if (v > 64'sd65535)
                r = 17'sd65535;
            else if (v < -64'sd65535)
                r = -17'sd65535;
            else
                r = v[16:0];
            return r;
        end
    endfunction

    // negate and saturate to [-32768, 32768]
    function automatic logic [16:0] sat_norm(input logic signed [63:0] n);
        logic signed [63:0] m;
        logic [16:0]        r;
        begin
            m = -n;
            if (m > 64'sd32768)
                r = 17'sd32768;
            else if (m < -64'sd32768)
                r = -17'sd32768;
            else
                r = m[16:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/uvsg_front.sv =====
`default_nettype none
module uvsg_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic [8:0]         row_in,
    input  wire logic [8:0]         col_in,
    output      uvsg_pkg::item_t    item,
    output      logic [15:0]        radius
);
    import uvsg_pkg::*;

    logic [15:0] radius_reg;
    logic [8:0]  slices_reg;
    logic [8:0]  stacks_reg;
    logic [8:0]  s_eff, t_eff, row_c, col_c;
    logic [17:0] k1_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            slices_reg <= SLICES_RST;
            stacks_reg <= STACKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data;
                REG_SLICES: slices_reg <= cfg_data[8:0];
                REG_STACKS: stacks_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (slices_reg == 9'd0)
            s_eff = 9'd1;
        else if (slices_reg > 9'(MAX_SLICES))
            s_eff = 9'(MAX_SLICES);
        else
            s_eff = slices_reg;
        if (stacks_reg == 9'd0)
            t_eff = 9'd1;
        else if (stacks_reg > 9'(MAX_STACKS))
            t_eff = 9'(MAX_STACKS);
        else
            t_eff = stacks_reg;
        row_c = (row_in > t_eff) ? t_eff : row_in;
        col_c = (col_in > s_eff) ? s_eff : col_in;
        k1_full = (18'(row_c) * (18'(s_eff) + 18'd1)) + 18'(col_c);

        item.row       = row_c;
        item.col       = col_c;
        item.slices    = s_eff;
        item.stacks    = t_eff;
        item.side.k1   = k1_full[16:0];
        item.side.k2   = 17'(k1_full + 18'(s_eff) + 18'd1);
        item.side.up   = (row_c != 9'd0) && (row_c < t_eff) && (col_c < s_eff);
        item.side.lo   = (row_c != 9'(t_eff - 9'd1)) && (row_c < t_eff) && (col_c < s_eff);
    end

    assign radius = radius_reg;

endmodule
`default_nettype wire

// ===== rtl/uvsg_fifo.sv =====
`default_nettype none
module uvsg_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire uvsg_pkg::item_t push_data,
    input  wire logic            pop,
    output      uvsg_pkg::item_t head,
    output      logic            empty,
    output      logic            full
);
    import uvsg_pkg::*;

    item_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/uvsg_cordic.sv =====
`default_nettype none
module uvsg_cordic (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [31:0]        phase,
    output      logic signed [31:0] cos_q,
    output      logic signed [31:0] sin_q
);
    import uvsg_pkg::*;

    logic signed [33:0] x_reg [CORDIC_STEPS];
    logic signed [33:0] y_reg [CORDIC_STEPS];
    logic signed [32:0] z_reg [CORDIC_STEPS];
    logic [1:0]         q_reg [CORDIC_STEPS];
    logic signed [31:0] cos_reg, sin_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [33:0] xi, yi, xo, yo;
        logic signed [32:0] zi, zo;
        logic [1:0]         qi;

        if (i == 0)
        begin : g_first
            assign xi = CORDIC_GAIN;
            assign yi = '0;
            assign zi = {3'b000, phase[29:0]};
            assign qi = phase[31:30];
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign qi = q_reg[i-1];
        end

        always_comb
        begin
            if (zi >= 0)
            begin
                xo = xi - (yi >>> i);
                yo = yi + (xi >>> i);
                zo = zi - $signed({1'b0, atan_turn(i)});
            end
            else
            begin
                xo = xi + (yi >>> i);
                yo = yi - (xi >>> i);
                zo = zi + $signed({1'b0, atan_turn(i)});
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= xo;
                y_reg[i] <= yo;
                z_reg[i] <= zo;
                q_reg[i] <= qi;
            end
        end
    end

    logic signed [31:0] xc, yc;

    always_comb
    begin
        if (x_reg[CORDIC_STEPS-1] > ONE_Q30)
            xc = 32'sd1073741824;
        else if (x_reg[CORDIC_STEPS-1] < -ONE_Q30)
            xc = -32'sd1073741824;
        else
            xc = x_reg[CORDIC_STEPS-1][31:0];
        if (y_reg[CORDIC_STEPS-1] > ONE_Q30)
            yc = 32'sd1073741824;
        else if (y_reg[CORDIC_STEPS-1] < -ONE_Q30)
            yc = -32'sd1073741824;
        else
            yc = y_reg[CORDIC_STEPS-1][31:0];
    end

    // restore quadrant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (q_reg[CORDIC_STEPS-1])
                2'd0:    begin cos_reg <= xc;  sin_reg <= yc;  end
                2'd1:    begin cos_reg <= -yc; sin_reg <= xc;  end
                2'd2:    begin cos_reg <= -xc; sin_reg <= -yc; end
                default: begin cos_reg <= yc;  sin_reg <= -xc; end
            endcase
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule
`default_nettype wire

// ===== rtl/uvsg_back.sv =====
`default_nettype none
module uvsg_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire uvsg_pkg::item_t head,
    input  wire logic            empty,
    output      logic            pop,
    input  wire logic [15:0]     radius,
    output      logic            m_tvalid,
    input  wire logic            m_tready,
    output      logic [175:0]    m_tdata
);
    import uvsg_pkg::*;

    logic en;
    logic out_vld_reg;
    assign en  = !out_vld_reg || m_tready;
    assign pop = en && !empty;

    // texture divider: one quotient bit per stage
    div_t                div_reg [DIV_BITS+1];
    logic [DIV_BITS:0]   div_vld_reg;
    div_t                div0;

    always_comb
    begin
        div0.slices = head.slices;
        div0.stacks = head.stacks;
        div0.side   = head.side;
        div0.q_u    = (head.col == head.slices) ? 17'h10000 : 17'd0;
        div0.rem_u  = (head.col == head.slices) ? 9'd0 : head.col;
        div0.q_v    = (head.row == head.stacks) ? 17'h10000 : 17'd0;
        div0.rem_v  = (head.row == head.stacks) ? 9'd0 : head.row;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            div_reg[0] <= div0;
    end

    for (genvar j = 1; j <= DIV_BITS; j++)
    begin : g_div
        logic [9:0] ru, rv;
        div_t       nxt;

        assign ru = {div_reg[j-1].rem_u, 1'b0};
        assign rv = {div_reg[j-1].rem_v, 1'b0};

        always_comb
        begin
            nxt = div_reg[j-1];
            if (ru >= {1'b0, div_reg[j-1].slices})
            begin
                nxt.rem_u = 9'(ru - {1'b0, div_reg[j-1].slices});
                nxt.q_u[DIV_BITS-j] = 1'b1;
            end
            else
                nxt.rem_u = ru[8:0];
            if (rv >= {1'b0, div_reg[j-1].stacks})
            begin
                nxt.rem_v = 9'(rv - {1'b0, div_reg[j-1].stacks});
                nxt.q_v[DIV_BITS-j] = 1'b1;
            end
            else
                nxt.rem_v = rv[8:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                div_reg[j] <= nxt;
        end
    end

    // angles
    logic [16:0] tu, tv;
    logic [31:0] stack_phase, sector_phase;
    logic signed [31:0] cs, ss, cc, sc;

    assign tu           = div_reg[DIV_BITS].q_u;
    assign tv           = div_reg[DIV_BITS].q_v;
    assign stack_phase  = 32'h4000_0000 - {tv, 15'd0};
    assign sector_phase = {tu[15:0], 16'd0};

    uvsg_cordic u_cordic_stack (
        .clk   (clk),
        .en    (en),
        .phase (stack_phase),
        .cos_q (cs),
        .sin_q (ss)
    );

    uvsg_cordic u_cordic_sector (
        .clk   (clk),
        .en    (en),
        .phase (sector_phase),
        .cos_q (cc),
        .sin_q (sc)
    );

    // sideband delay matching the CORDIC
    post_t                 post_reg [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] post_vld_reg;
    post_t                 post0;

    assign post0.tex_u = tu;
    assign post0.tex_v = tv;
    assign post0.side  = div_reg[DIV_BITS].side;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            post_reg[0] <= post0;
            for (int k = 1; k <= CORDIC_STEPS; k++)
                post_reg[k] <= post_reg[k-1];
        end
    end

    // products
    logic signed [48:0] m1_xy_reg, m1_pz_reg;
    logic signed [63:0] m1_nx_reg, m1_ny_reg;
    logic signed [31:0] m1_cc_reg, m1_sc_reg, m1_ss_reg;
    post_t              m1_post_reg;

    logic signed [25:0] m2_xy_reg;
    logic signed [31:0] m2_cc_reg, m2_sc_reg;
    logic [16:0]        m2_pz_reg, m2_nx_reg, m2_ny_reg, m2_nz_reg;
    post_t              m2_post_reg;

    logic signed [57:0] m3_px_reg, m3_py_reg;
    logic [16:0]        m3_pz_reg, m3_nx_reg, m3_ny_reg, m3_nz_reg;
    post_t              m3_post_reg;

    logic [2:0]         m_vld_reg;
    logic [175:0]       out_data_reg;

    logic signed [63:0] xy_w, pz_w, nx_w, ny_w, nz_w, px_w, py_w;

    always_comb
    begin
        xy_w = (64'(m1_xy_reg) + 64'sd2097152) >>> 22;
        pz_w = (64'(m1_pz_reg) + 64'sd536870912) >>> 30;
        nx_w = (m1_nx_reg + 64'sd17592186044416) >>> 45;
        ny_w = (m1_ny_reg + 64'sd17592186044416) >>> 45;
        nz_w = (64'(m1_ss_reg) + 64'sd16384) >>> 15;
        px_w = (64'(m3_px_reg) + 64'sd137438953472) >>> 38;
        py_w = (64'(m3_py_reg) + 64'sd137438953472) >>> 38;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_xy_reg   <= $signed({1'b0, radius}) * cs;
            m1_pz_reg   <= $signed({1'b0, radius}) * ss;
            m1_nx_reg   <= cs * cc;
            m1_ny_reg   <= cs * sc;
            m1_cc_reg   <= cc;
            m1_sc_reg   <= sc;
            m1_ss_reg   <= ss;
            m1_post_reg <= post_reg[CORDIC_STEPS];

            m2_xy_reg   <= xy_w[25:0];
            m2_cc_reg   <= m1_cc_reg;
            m2_sc_reg   <= m1_sc_reg;
            m2_pz_reg   <= sat_pos(pz_w);
            m2_nx_reg   <= sat_norm(nx_w);
            m2_ny_reg   <= sat_norm(ny_w);
            m2_nz_reg   <= sat_norm(nz_w);
            m2_post_reg <= m1_post_reg;

            m3_px_reg   <= m2_xy_reg * m2_cc_reg;
            m3_py_reg   <= m2_xy_reg * m2_sc_reg;
            m3_pz_reg   <= m2_pz_reg;
            m3_nx_reg   <= m2_nx_reg;
            m3_ny_reg   <= m2_ny_reg;
            m3_nz_reg   <= m2_nz_reg;
            m3_post_reg <= m2_post_reg;

            out_data_reg <= {4'd0,
                             m3_post_reg.side.lo, m3_post_reg.side.up,
                             m3_post_reg.side.k2, m3_post_reg.side.k1,
                             m3_nz_reg, m3_ny_reg, m3_nx_reg,
                             m3_post_reg.tex_v, m3_post_reg.tex_u,
                             m3_pz_reg, sat_pos(py_w), sat_pos(px_w)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg  <= '0;
            post_vld_reg <= '0;
            m_vld_reg    <= '0;
            out_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            div_vld_reg  <= {div_vld_reg[DIV_BITS-1:0], !empty};
            post_vld_reg <= {post_vld_reg[CORDIC_STEPS-1:0], div_vld_reg[DIV_BITS]};
            m_vld_reg    <= {m_vld_reg[1:0], post_vld_reg[CORDIC_STEPS]};
            out_vld_reg  <= m_vld_reg[2];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ===== rtl/uv_sphere_vertex_generator_unit.sv =====
// Throughput: one beat per cycle while m_tready does not stall the output;
// the divider and both CORDIC units are fully pipelined, one quotient bit
// and one rotation per stage.
// A four-entry queue decouples input acceptance from the pipeline stall.
// Reset (rst_n low, asynchronous) empties queue and pipeline and loads
// radius 256, 16 slices, 8 stacks.
`default_nettype none
module uv_sphere_vertex_generator_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output      logic         cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    // row_index[8:0], column_index[17:9], zero pad [23:18]
    input  wire logic [23:0]  s_tdata,
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z, base_index,
    // below_index (17 bits each from bit 0), upper_tri_valid[170],
    // lower_tri_valid[171], zero pad [175:172]
    output      logic [175:0] m_tdata
);
    import uvsg_pkg::*;

    item_t       item, head;
    logic [15:0] radius;
    logic        full, empty, pop, push;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign push      = s_tvalid && !full;

    uvsg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row_in    (s_tdata[8:0]),
        .col_in    (s_tdata[17:9]),
        .item      (item),
        .radius    (radius)
    );

    uvsg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (item),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    uvsg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .radius   (radius),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/uvsg_checker.sv =====
`default_nettype none
module uvsg_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [175:0] m_tdata
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

    a_k2_above_k1: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[169:153] > m_tdata[152:136])
        else $error("below_index not above base_index");

    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[67:51] <= 17'd65536) && (m_tdata[84:68] <= 17'd65536))
        else $error("texture coordinate above one");

endmodule

bind uv_sphere_vertex_generator_unit uvsg_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/uv_sphere_vertex_generator_unit_tb.sv =====
`default_nettype none
module uv_sphere_vertex_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import uvsg_pkg::*;

    localparam int LATENCY     = 38;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [8:0] row;
        logic [8:0] col;
    } grid_pt_t;

    typedef struct packed {
        logic [16:0] pos_x, pos_y, pos_z;
        logic [16:0] tex_u, tex_v;
        logic [16:0] norm_x, norm_y, norm_z;
        logic [16:0] k1, k2;
        logic        up, lo;
    } vertex_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;

    uv_sphere_vertex_generator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // shadow registers
    logic [15:0] radius_q;
    logic [8:0]  slices_q;
    logic [8:0]  stacks_q;

    grid_pt_t pending_pts[$];
    vertex_t  vertex_fifo[$];
    int       errors;
    int       cycles;
    int       beats_in;
    int       beats_out;
    bit       hold_sender;
    bit       cfg_busy;
    int       burst_left;
    int       gap_left;
    int       stall_mode;

    localparam longint ATAN_TBL[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic rotate_phase(input logic [31:0] phase, output longint c,
                                output longint s);
        longint x, y, z, dx, dy;
        x = 652032874;
        y = 0;
        z = longint'(phase[29:0]);
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        x = clip(x, -1073741824, 1073741824);
        y = clip(y, -1073741824, 1073741824);
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic longint neg_norm(longint prod, int sh);
        return clip(-floor_shr(prod + (longint'(1) << (sh - 1)), sh), -32768, 32768);
    endfunction

    task automatic predict_vertex(input grid_pt_t p, output vertex_t v);
        longint sl, st, row, col, tu, tv, r, cs, ss, cc, sc, xy, px, py, pz, k1;
        logic [31:0] ph;
        sl = slices_q;
        st = stacks_q;
        r = radius_q;
        if (sl == 0) sl = 1;
        if (sl > MAX_SLICES) sl = MAX_SLICES;
        if (st == 0) st = 1;
        if (st > MAX_STACKS) st = MAX_STACKS;
        row = p.row > st ? st : p.row;
        col = p.col > sl ? sl : p.col;
        tu = (col << 16) / sl;
        tv = (row << 16) / st;
        ph = 32'h4000_0000 - 32'(tv << 15);
        rotate_phase(ph, cs, ss);
        ph = 32'(tu << 16);
        rotate_phase(ph, cc, sc);
        xy = floor_shr(r * cs + (longint'(1) << 21), 22);
        px = floor_shr(xy * cc + (longint'(1) << 37), 38);
        py = floor_shr(xy * sc + (longint'(1) << 37), 38);
        pz = floor_shr(r * ss + (longint'(1) << 29), 30);
        k1 = row * (sl + 1) + col;
        v.pos_x  = 17'(clip(px, -65535, 65535));
        v.pos_y  = 17'(clip(py, -65535, 65535));
        v.pos_z  = 17'(clip(pz, -65535, 65535));
        v.tex_u  = 17'(tu);
        v.tex_v  = 17'(tv);
        v.norm_x = 17'(neg_norm(cs * cc, 45));
        v.norm_y = 17'(neg_norm(cs * sc, 45));
        v.norm_z = 17'(neg_norm(ss, 15));
        v.k1     = 17'(k1);
        v.k2     = 17'(k1 + sl + 1);
        v.up     = row != 0 && row < st && col < sl;
        v.lo     = row != st - 1 && row < st && col < sl;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                vertex_t v;
                predict_vertex(pending_pts.pop_front(), v);
                vertex_fifo.insert(vertex_fifo.size(), v);
                beats_in++;
            end
            if (s_tvalid && !s_tready)
                ;  // hold the beat
            else if (pending_pts.size() == 0 || hold_sender || cfg_busy)
                s_tvalid <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
                burst_left--;
                s_tvalid <= 1'b1;
                s_tdata  <= {6'd0, pending_pts[0].col, pending_pts[0].row};
            end
        end
    end

    // monitor with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                vertex_t a, e;
                a.pos_x  = m_tdata[16:0];
                a.pos_y  = m_tdata[33:17];
                a.pos_z  = m_tdata[50:34];
                a.tex_u  = m_tdata[67:51];
                a.tex_v  = m_tdata[84:68];
                a.norm_x = m_tdata[101:85];
                a.norm_y = m_tdata[118:102];
                a.norm_z = m_tdata[135:119];
                a.k1     = m_tdata[152:136];
                a.k2     = m_tdata[169:153];
                a.up     = m_tdata[170];
                a.lo     = m_tdata[171];
                beats_out++;
                if (vertex_fifo.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected output beat %h", $time, m_tdata);
                end
                else
                begin
                    e = vertex_fifo.pop_front();
                    if (a !== e)
                    begin
                        errors++;
                        $display("%0t: vertex mismatch expected %p actual %p", $time, e, a);
                    end
                end
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= cycles[3];
            endcase
            if (cycles % 300 == 0)
                stall_mode = $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("uv_sphere_vertex_generator_unit_tb failed");
            $finish;
        end
    end

    task automatic drain_and_settle();
        while (pending_pts.size() != 0 || s_tvalid)
            @(posedge clk);
        while (vertex_fifo.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RADIUS: radius_q = val;
            REG_SLICES: slices_q = val[8:0];
            REG_STACKS: stacks_q = val[8:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] r, input logic [8:0] sl,
                             input logic [8:0] st);
        drain_and_settle();
        cfg_busy = 1;
        write_reg(REG_RADIUS, r);
        write_reg(REG_SLICES, {7'd0, sl});
        write_reg(REG_STACKS, {7'd0, st});
        cfg_busy = 0;
    endtask

    task automatic add_pt(input int row, input int col);
        grid_pt_t p;
        p.row = 9'(row);
        p.col = 9'(col);
        pending_pts.insert(pending_pts.size(), p);
    endtask

    task automatic add_random(input int n);
        int sl, st;
        for (int i = 0; i < n; i++)
        begin
            sl = slices_q == 0 ? 1 : slices_q;
            st = stacks_q == 0 ? 1 : stacks_q;
            if ($urandom_range(0, 9) < 8)
                add_pt($urandom_range(0, st), $urandom_range(0, sl));
            else
                add_pt($urandom_range(0, 511), $urandom_range(0, 511));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        errors = 0;
        cycles = 0;
        beats_in = 0;
        beats_out = 0;
        hold_sender = 0;
        cfg_busy = 0;
        stall_mode = 0;
        radius_q = RADIUS_RST;
        slices_q = SLICES_RST;
        stacks_q = STACKS_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: poles, equator, last row and column, clamped indices
        add_pt(0, 0);
        add_pt(4, 4);
        add_pt(7, 15);
        add_pt(8, 16);
        add_pt(8, 0);
        add_pt(0, 16);
        add_pt(511, 511);
        add_pt(300, 2);
        add_pt(3, 257);
        add_pt(1, 8);
        add_pt(6, 12);
        add_pt(9'h155, 9'h0AA);
        add_pt(9'h0AA, 9'h155);

        // zero counts act as one, zero radius
        configure(16'd0, 9'd0, 9'd0);
        add_pt(0, 0);
        add_pt(1, 1);
        add_pt(2, 5);

        // max radius, counts above maximum saturate
        configure(16'hFFFF, 9'd511, 9'd257);
        add_pt(0, 0);
        add_pt(128, 64);
        add_pt(256, 256);
        add_pt(255, 255);
        add_pt(511, 511);
        add_pt(64, 192);

        // unknown register index is ignored
        drain_and_settle();
        cfg_busy = 1;
        write_reg(2'd3, 16'hFFFF);
        cfg_busy = 0;
        configure(16'h0180, 9'd256, 9'd256);
        add_pt(256, 256);
        add_pt(255, 0);

        add_random(120);
        configure(16'h8000, 9'd3, 9'd2);
        add_random(80);

        // sender holds mid-stream until everything is back
        while (pending_pts.size() > 40)
            @(posedge clk);
        hold_sender = 1;
        while (s_tvalid || vertex_fifo.size() != 0)
            @(posedge clk);
        hold_sender = 0;

        configure(16'd1, 9'd1, 9'd1);
        add_random(50);
        configure(16'($urandom_range(0, 65535)), 9'($urandom_range(0, 511)),
                  9'($urandom_range(0, 511)));
        add_random(100);
        configure(16'd256, 9'd37, 9'd19);
        add_random(100);

        drain_and_settle();
        $display("covered %0d grid points over several radius and count settings", beats_in);
        $display("%0d output beats checked, %0d mismatches", beats_out, errors);
        if (errors == 0 && vertex_fifo.size() == 0)
            $display("uv_sphere_vertex_generator_unit_tb passed");
        else
            $display("uv_sphere_vertex_generator_unit_tb failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/uvsg_pkg.sv
rtl/uvsg_front.sv
rtl/uvsg_fifo.sv
rtl/uvsg_cordic.sv
rtl/uvsg_back.sv
rtl/uv_sphere_vertex_generator_unit.sv
rtl/uvsg_checker.sv
tb/uv_sphere_vertex_generator_unit_tb.sv
